@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define URB_ASSERT_NOW(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Property whose antecedent implies the consequent in the same cycle.
`define URB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Property whose antecedent implies the consequent in the next cycle.
`define URB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/urb_pkg.sv @@
// Package with the types, codes and defaults of the UART ring buffer block.
`default_nettype none
package urb_pkg;

  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int RING_DEPTH_DEF  = 256;

  localparam logic [KIND_W-1:0] KIND_PUT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_RX = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TX_RDY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TX_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RX_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RX_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TX_IDLE  = 3'd4;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/urb_if.sv @@
// Valid/ready channel interfaces for events in and results out.
`default_nettype none
interface urb_in_if
  import urb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface urb_out_if
  import urb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   byte_out;
  logic                line_send;
  logic                tx_ready_enabled;

  modport source (output valid, output status, output byte_out, output line_send,
                  output tx_ready_enabled, input ready);
  modport sink   (input valid, input status, input byte_out, input line_send,
                  input tx_ready_enabled, output ready);
endinterface
`default_nettype wire

@@ rtl/core/urb_ring.sv @@
// Circular byte queue: storage, read and write pointers, registered read data.
`default_nettype none
module urb_ring
  import urb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ring_cmd_t         cmd,
  input  wire logic [BYTE_W-1:0] wdata,
  output ring_stat_t             stat,
  output logic [BYTE_W-1:0]      rdata_r
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_nxt;

  assign rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;

  assign stat.full  = (wr_ptr_nxt == rd_ptr_r);
  assign stat.empty = (wr_ptr_r == rd_ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (cmd.pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr_r] <= wdata;
    end
    if (cmd.pop) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/urb_ctrl.sv @@
// Event decoder, transmit-ready enable and result register.
`default_nettype none
module urb_ctrl
  import urb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [KIND_W-1:0] kind,
  input  wire ring_stat_t        rx_stat,
  input  wire ring_stat_t        tx_stat,
  input  wire logic [BYTE_W-1:0] rx_rdata,
  input  wire logic [BYTE_W-1:0] tx_rdata,
  input  wire logic              out_ready,
  output ring_cmd_t              rx_cmd,
  output ring_cmd_t              tx_cmd,
  output logic                   in_ready,
  output logic                   out_valid_r,
  output logic [STATUS_W-1:0]    status_r,
  output logic [BYTE_W-1:0]      byte_out,
  output logic                   line_send_r,
  output logic                   enable_r
);

  logic                out_valid_nxt;
  logic                enable_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic                line_send_nxt;
  logic                sel_rx_nxt;
  logic                sel_tx_nxt;
  logic                sel_rx_r;
  logic                sel_tx_r;
  ring_cmd_t           rx_c;
  ring_cmd_t           tx_c;

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    enable_nxt    = enable_r;
    status_nxt    = ST_DONE;
    line_send_nxt = 1'b0;
    sel_rx_nxt    = 1'b0;
    sel_tx_nxt    = 1'b0;
    rx_c          = '0;
    tx_c          = '0;
    case (kind)
      KIND_PUT: begin
        if (tx_stat.full) begin
          status_nxt = ST_TX_FULL;
        end else begin
          tx_c.push  = 1'b1;
          enable_nxt = 1'b1;
        end
      end
      KIND_GET: begin
        if (rx_stat.empty) begin
          status_nxt = ST_RX_EMPTY;
        end else begin
          rx_c.pop   = 1'b1;
          sel_rx_nxt = 1'b1;
        end
      end
      KIND_LINE_RX: begin
        if (rx_stat.full) begin
          status_nxt = ST_RX_FULL;
        end else begin
          rx_c.push = 1'b1;
        end
      end
      KIND_TX_RDY: begin
        if (!enable_r) begin
          status_nxt = ST_TX_IDLE;
        end else if (!tx_stat.empty) begin
          tx_c.pop      = 1'b1;
          sel_tx_nxt    = 1'b1;
          line_send_nxt = 1'b1;
        end else begin
          enable_nxt = 1'b0;
          status_nxt = ST_TX_IDLE;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  assign rx_cmd = accept ? rx_c : '0;
  assign tx_cmd = accept ? tx_c : '0;

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      enable_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        enable_r <= enable_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      line_send_r <= line_send_nxt;
      sel_rx_r    <= sel_rx_nxt;
      sel_tx_r    <= sel_tx_nxt;
    end
  end

  // The ring read data is registered on the same edge as the result.
  assign byte_out = sel_rx_r ? rx_rdata : (sel_tx_r ? tx_rdata : '0);

endmodule
`default_nettype wire

@@ rtl/core/uart_rx_tx_ring_buffers_top.sv @@
// Top level of the UART receive and transmit ring buffer pair.
//
//  Channel   Direction  Handshake    Payload
//  in_ch     in         valid/ready  kind, data_byte
//  out_ch    out        valid/ready  status, byte_out, line_send, tx_ready_enabled
//
// One event is taken per cycle unless a stalled result holds in_ready low; its result
// appears on the following cycle. The read port of each ring memory is registered.
// Synchronous reset empties both rings and clears the transmit-ready enable.
// A stalled result holds, and a new transaction is taken in the cycle it leaves.
`default_nettype none
module uart_rx_tx_ring_buffers_top
  import urb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  urb_in_if.sink     in_ch,
  urb_out_if.source  out_ch
);

  logic              accept;
  ring_stat_t        rx_stat;
  ring_stat_t        tx_stat;
  ring_cmd_t         rx_cmd;
  ring_cmd_t         tx_cmd;
  logic [BYTE_W-1:0] rx_rdata;
  logic [BYTE_W-1:0] tx_rdata;
  logic              in_ready;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  urb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rx_cmd),
    .wdata   (in_ch.data_byte),
    .stat    (rx_stat),
    .rdata_r (rx_rdata)
  );

  urb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (tx_cmd),
    .wdata   (in_ch.data_byte),
    .stat    (tx_stat),
    .rdata_r (tx_rdata)
  );

  urb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .kind        (in_ch.kind),
    .rx_stat     (rx_stat),
    .tx_stat     (tx_stat),
    .rx_rdata    (rx_rdata),
    .tx_rdata    (tx_rdata),
    .out_ready   (out_ch.ready),
    .rx_cmd      (rx_cmd),
    .tx_cmd      (tx_cmd),
    .in_ready    (in_ready),
    .out_valid_r (out_ch.valid),
    .status_r    (out_ch.status),
    .byte_out    (out_ch.byte_out),
    .line_send_r (out_ch.line_send),
    .enable_r    (out_ch.tx_ready_enabled)
  );

endmodule
`default_nettype wire

@@ rtl/core/urb_checker.sv @@
// Port-level checker for the ring buffer top level, with its bind statement.
`default_nettype none
`include "assert_macros.svh"
module urb_checker
  import urb_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [BYTE_W-1:0]   byte_out,
  input wire logic                line_send,
  input wire logic                tx_ready_enabled
);

  // Every accepted transaction produces a result on the next cycle.
  `URB_ASSERT_NXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "no result after accepted transaction")
  // A byte sent to the line is a successful event with the enable still set.
  `URB_ASSERT_IMP(a_send_ok, clk, rst_n, out_valid && line_send, (status == ST_DONE) && tx_ready_enabled, "line send with bad status or enable")
  // Transmitter idle always leaves the enable clear.
  `URB_ASSERT_IMP(a_idle_clears, clk, rst_n, out_valid && (status == ST_TX_IDLE), !tx_ready_enabled, "transmitter idle with enable set")
  // Status codes stay within the defined set.
  `URB_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status <= ST_TX_IDLE, "status code out of range")
  // A stalled result holds its byte.
  `URB_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(byte_out), "stalled result changed")

endmodule

bind uart_rx_tx_ring_buffers_top urb_checker u_urb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .byte_out         (out_ch.byte_out),
  .line_send        (out_ch.line_send),
  .tx_ready_enabled (out_ch.tx_ready_enabled)
);
`default_nettype wire
